/* rtl/quaternion_slerp_top_defines.svh */
// Assertion macros used by the port-level checker.
`ifndef QUATERNION_SLERP_TOP_DEFINES_SVH
`define QUATERNION_SLERP_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define QS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define QS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Check that holds while reset is asserted.
`define QS_ASSERT_RESET(label, cons, msg) \
	label: assert property (@(posedge clk) !arst_n |-> (cons)) else $error(msg);

`endif

/* rtl/qslerp_pkg.sv */
`default_nettype none
package qslerp_pkg;

	// Component width (signed Q1.15).
	localparam int COMP_W = 16;
	// Width of the CORDIC and dot-product datapath.
	localparam int CW = 34;
	// Width of a Q30 weight in [0, 1].
	localparam int WT_W = 31;
	localparam int THR_W = 31;
	localparam logic [THR_W-1:0] THR_RESET = 31'd1074;
	localparam logic [WT_W-1:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [16:0] T_ONE = 17'h1_0000;
	// Square root steps (one result bit from two radicand bits each) and quotient bits.
	localparam int SQ_STEPS = 31;
	localparam int DIV_STEPS = 30;

	// Rounded atan(2^-i) in Q30 radians.
	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
	};

	typedef struct packed {
		logic signed [COMP_W-1:0] start_w;
		logic signed [COMP_W-1:0] start_x;
		logic signed [COMP_W-1:0] start_y;
		logic signed [COMP_W-1:0] start_z;
		logic signed [COMP_W-1:0] end_w;
		logic signed [COMP_W-1:0] end_x;
		logic signed [COMP_W-1:0] end_y;
		logic signed [COMP_W-1:0] end_z;
		logic [16:0] blend_t;
	} slerp_in_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] out_w;
		logic signed [COMP_W-1:0] out_x;
		logic signed [COMP_W-1:0] out_y;
		logic signed [COMP_W-1:0] out_z;
		logic used_linear;
		logic flipped;
	} slerp_out_t;

endpackage
`default_nettype wire

/* rtl/qslerp_cordic.sv */
`default_nettype none
// Pipelined CORDIC, one micro-rotation per register stage.
// Vectoring mode drives y toward zero; rotation mode drives z toward zero.
module qslerp_cordic #(
	parameter int ITER = 16,
	parameter bit VECTOR = 1'b0
) (
	input  logic clk,
	input  logic en,
	input  logic signed [qslerp_pkg::CW-1:0] x_in,
	input  logic signed [qslerp_pkg::CW-1:0] y_in,
	input  logic signed [qslerp_pkg::CW-1:0] z_in,
	output logic signed [qslerp_pkg::CW-1:0] x_out,
	output logic signed [qslerp_pkg::CW-1:0] y_out,
	output logic signed [qslerp_pkg::CW-1:0] z_out
);
	import qslerp_pkg::*;

	logic signed [CW-1:0] x_s [1:ITER];
	logic signed [CW-1:0] y_s [1:ITER];
	logic signed [CW-1:0] z_s [1:ITER];

	for (genvar i = 0; i < ITER; i++) begin : g_step
		logic signed [CW-1:0] xc, yc, zc, dx, dy, ang;
		logic neg_dir;

		if (i == 0) begin : g_first
			assign xc = x_in;
			assign yc = y_in;
			assign zc = z_in;
		end else begin : g_rest
			assign xc = x_s[i];
			assign yc = y_s[i];
			assign zc = z_s[i];
		end

		// Floor shifts and the angle of this step.
		assign dx = yc >>> i;
		assign dy = xc >>> i;
		assign ang = $signed({{(CW-30){1'b0}}, ATAN_Q30[i]});
		assign neg_dir = VECTOR ? yc[CW-1] : !zc[CW-1];

		always_ff @(posedge clk) begin
			if (en) begin
				if (neg_dir) begin
					x_s[i+1] <= xc - dx;
					y_s[i+1] <= yc + dy;
					z_s[i+1] <= zc - ang;
				end else begin
					x_s[i+1] <= xc + dx;
					y_s[i+1] <= yc - dy;
					z_s[i+1] <= zc + ang;
				end
			end
		end
	end

	assign x_out = x_s[ITER];
	assign y_out = y_s[ITER];
	assign z_out = z_s[ITER];

endmodule
`default_nettype wire

/* rtl/qslerp_ratio.sv */
`default_nettype none
// Pipelined restoring divider for a weight num / den in Q30, clamped to [0, 1].
// One setup stage, then one quotient bit per stage.
module qslerp_ratio (
	input  logic clk,
	input  logic en,
	input  logic signed [qslerp_pkg::CW-1:0] num,
	input  logic signed [qslerp_pkg::CW-1:0] den,
	output logic [qslerp_pkg::WT_W-1:0] weight
);
	import qslerp_pkg::*;

	logic zero_s0, sat_s0;
	logic [32:0] rem_s0, den_s0;
	logic zero_s [1:DIV_STEPS];
	logic sat_s [1:DIV_STEPS];
	logic [32:0] rem_s [1:DIV_STEPS];
	logic [32:0] den_s [1:DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_s [1:DIV_STEPS];

	// Setup: a negative numerator gives zero, num >= den saturates at one.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s0 <= num[CW-1];
			sat_s0 <= (num >= den);
			rem_s0 <= num[32:0];
			den_s0 <= den[32:0];
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic zc, sc, ge;
		logic [32:0] rc, dc, r2;
		logic [DIV_STEPS-1:0] qc;

		if (j == 0) begin : g_first
			assign zc = zero_s0;
			assign sc = sat_s0;
			assign rc = rem_s0;
			assign dc = den_s0;
			assign qc = '0;
		end else begin : g_rest
			assign zc = zero_s[j];
			assign sc = sat_s[j];
			assign rc = rem_s[j];
			assign dc = den_s[j];
			assign qc = quo_s[j];
		end

		assign r2 = {rc[31:0], 1'b0};
		assign ge = (r2 >= dc);

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[j+1] <= zc;
				sat_s[j+1] <= sc;
				den_s[j+1] <= dc;
				rem_s[j+1] <= ge ? (r2 - dc) : r2;
				quo_s[j+1] <= {qc[DIV_STEPS-2:0], ge};
			end
		end
	end

	always_comb begin
		if (zero_s[DIV_STEPS]) begin
			weight = '0;
		end else if (sat_s[DIV_STEPS]) begin
			weight = ONE_Q30;
		end else begin
			weight = {1'b0, quo_s[DIV_STEPS]};
		end
	end

endmodule
`default_nettype wire

/* rtl/quaternion_slerp_top.sv */
`default_nettype none
// Channel | Signals                        | Transaction
// --------+--------------------------------+--------------------------------------
// request | req_valid, req_stall, req_data | start and end quaternion, blend_t
// result  | rsp_valid, rsp_stall, rsp_data | blended quaternion and two flags
// config  | cfg_we, cfg_data               | linear_threshold write, no read-back
//
// One transaction enters per cycle while req_stall is low; it passes through the
// 31-stage square root, the two CORDIC pipelines and the 31-stage divider.
// The whole pipeline advances together. A skid register takes a result that waits
// under rsp_stall, so the pipeline moves once more; it holds, and req_stall is
// high, only while that register is full.
// arst_n clears the valid bits and loads linear_threshold with its reset value.
module quaternion_slerp_top #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  qslerp_pkg::slerp_in_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output qslerp_pkg::slerp_out_t rsp_data,
	input  logic cfg_we,
	input  logic [qslerp_pkg::THR_W-1:0] cfg_data
);
	import qslerp_pkg::*;

	localparam int P_DOT = 1;
	localparam int P_SQ = 2;
	localparam int P_N = 3;
	localparam int P_SQRT_END = P_N + SQ_STEPS;
	localparam int P_VEC_END = P_SQRT_END + TRIG_ITERATIONS;
	localparam int P_ANG = P_VEC_END + 1;
	localparam int P_ROT_END = P_ANG + TRIG_ITERATIONS;
	localparam int P_DIV_END = P_ROT_END + DIV_STEPS + 1;
	localparam int P_WMUL = P_DIV_END + 1;
	localparam int P_OUT = P_WMUL + 1;
	localparam int LAT = P_OUT + 1;
	localparam int SIDE_N = P_WMUL + 1;

	typedef struct packed {
		slerp_in_t item;
		logic flip;
		logic lin;
		logic [30:0] d;
	} side_t;

	logic en;
	logic [THR_W-1:0] thr_q;
	logic [LAT-1:0] vld_q;
	side_t side_q [SIDE_N];
	side_t side_in;
	slerp_out_t res_q, skid_q;
	logic skid_vld_q;

	// Global advance: everything moves unless the skid register is full.
	assign en = !skid_vld_q;
	assign req_stall = skid_vld_q;
	assign rsp_valid = skid_vld_q || vld_q[LAT-1];
	assign rsp_data = skid_vld_q ? skid_q : res_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req_valid};
		end
	end

	// Skid register: filled when the last stage is held, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (!rsp_stall) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_q[LAT-1] && rsp_stall) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld_q[LAT-1] && rsp_stall) begin
			skid_q <= res_q;
		end
	end

	// Clamp blend_t to one on entry.
	always_comb begin
		side_in = '0;
		side_in.item = req_data;
		if (req_data.blend_t > T_ONE) begin
			side_in.item.blend_t = T_ONE;
		end
	end

	// Stage 1: the four component products, already Q30.
	logic signed [2*COMP_W-1:0] prod_s1 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= req_data.start_w * req_data.end_w;
			prod_s1[1] <= req_data.start_x * req_data.end_x;
			prod_s1[2] <= req_data.start_y * req_data.end_y;
			prod_s1[3] <= req_data.start_z * req_data.end_z;
		end
	end

	// Stage 2: dot sum, sign fold, threshold compare and clamp to one.
	logic signed [CW-1:0] dot_c, adot_c;
	logic signed [CW:0] gap_c;
	logic flip_c, lin_c;
	logic [30:0] d_c;
	always_comb begin
		dot_c = CW'(prod_s1[0]) + CW'(prod_s1[1]) + CW'(prod_s1[2]) + CW'(prod_s1[3]);
		flip_c = dot_c[CW-1];
		adot_c = flip_c ? -dot_c : dot_c;
		gap_c = $signed({4'b0, ONE_Q30}) - $signed({adot_c[CW-1], adot_c});
		lin_c = gap_c < $signed({4'b0, thr_q});
		d_c = (adot_c > $signed({3'b0, ONE_Q30})) ? ONE_Q30 : adot_c[30:0];
	end

	// Sideband entries rewritten by the stages that decide them.
	logic sth_nonpos;
	side_t side_dot, side_rot;
	always_comb begin
		side_dot = side_q[P_DOT-1];
		side_dot.flip = flip_c;
		side_dot.lin = lin_c;
		side_dot.d = d_c;
		side_rot = side_q[P_ROT_END];
		side_rot.lin = side_q[P_ROT_END].lin | sth_nonpos;
	end

	// Sideband line that moves with the pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int k = 1; k < SIDE_N; k++) begin
				if (k == P_DOT) begin
					side_q[k] <= side_dot;
				end else if (k == P_ROT_END + 1) begin
					side_q[k] <= side_rot;
				end else begin
					side_q[k] <= side_q[k-1];
				end
			end
		end
	end

	// Stage 3 and 4: d squared, then the radicand 2^60 - d^2.
	logic [61:0] dd_s3, root_n_s0;
	always_ff @(posedge clk) begin
		if (en) begin
			dd_s3 <= side_q[P_DOT].d * side_q[P_DOT].d;
			root_n_s0 <= (62'(1) << 60) - dd_s3;
		end
	end

	// Integer square root, one result bit per stage.
	logic [61:0] root_n_s [1:SQ_STEPS];
	logic [61:0] root_r_s [1:SQ_STEPS];
	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		localparam logic [61:0] BITV = 62'(1) << (2 * (SQ_STEPS - 1 - j));
		logic [61:0] nc, rc, trial;
		logic ge;

		if (j == 0) begin : g_first
			assign nc = root_n_s0;
			assign rc = '0;
		end else begin : g_rest
			assign nc = root_n_s[j];
			assign rc = root_r_s[j];
		end

		assign trial = rc + BITV;
		assign ge = (nc >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_n_s[j+1] <= ge ? (nc - trial) : nc;
				root_r_s[j+1] <= ge ? ((rc >> 1) + BITV) : (rc >> 1);
			end
		end
	end

	// theta = atan2(sqrt(1 - d^2), d) by vectoring.
	logic signed [CW-1:0] vx, vy, vz;
	qslerp_cordic #(.ITER(TRIG_ITERATIONS), .VECTOR(1'b1)) u_vec (
		.clk   (clk),
		.en    (en),
		.x_in  ($signed({3'b0, side_q[P_SQRT_END].d})),
		.y_in  ($signed({3'b0, root_r_s[SQ_STEPS][30:0]})),
		.z_in  ('0),
		.x_out (vx),
		.y_out (vy),
		.z_out (vz)
	);

	// Clamp theta at zero and scale it by 1 - t and by t.
	logic [30:0] theta_c, theta_s4, anga_s4, angb_s4;
	logic [16:0] tinv_c;
	logic [47:0] pa_c, pb_c;
	always_comb begin
		theta_c = vz[CW-1] ? '0 : vz[30:0];
		tinv_c = T_ONE - side_q[P_VEC_END].item.blend_t;
		pa_c = tinv_c * theta_c;
		pb_c = side_q[P_VEC_END].item.blend_t * theta_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			theta_s4 <= theta_c;
			anga_s4 <= pa_c[46:16];
			angb_s4 <= pb_c[46:16];
		end
	end

	// Three sines by rotation from (2^30, 0).
	localparam logic signed [CW-1:0] X0 = $signed({3'b0, ONE_Q30});
	logic signed [CW-1:0] sth, ss, se;
	logic signed [CW-1:0] ux0, uz0, ux1, uz1, ux2, uz2;

	qslerp_cordic #(.ITER(TRIG_ITERATIONS), .VECTOR(1'b0)) u_sin_th (
		.clk (clk), .en (en),
		.x_in (X0), .y_in ('0), .z_in ($signed({3'b0, theta_s4})),
		.x_out (ux0), .y_out (sth), .z_out (uz0)
	);
	qslerp_cordic #(.ITER(TRIG_ITERATIONS), .VECTOR(1'b0)) u_sin_a (
		.clk (clk), .en (en),
		.x_in (X0), .y_in ('0), .z_in ($signed({3'b0, anga_s4})),
		.x_out (ux1), .y_out (ss), .z_out (uz1)
	);
	qslerp_cordic #(.ITER(TRIG_ITERATIONS), .VECTOR(1'b0)) u_sin_b (
		.clk (clk), .en (en),
		.x_in (X0), .y_in ('0), .z_in ($signed({3'b0, angb_s4})),
		.x_out (ux2), .y_out (se), .z_out (uz2)
	);

	// A sine of theta that is not positive forces the linear weights.
	assign sth_nonpos = sth[CW-1] || (sth == '0);

	// Slerp weights as quotients of the sines.
	logic [WT_W-1:0] wa_div, wb_div;
	qslerp_ratio u_div_a (.clk (clk), .en (en), .num (ss), .den (sth), .weight (wa_div));
	qslerp_ratio u_div_b (.clk (clk), .en (en), .num (se), .den (sth), .weight (wb_div));

	// Weight selection and the eight blend products.
	side_t sw;
	logic [WT_W-1:0] ws_c, we_c;
	logic signed [WT_W:0] wes_c;
	logic signed [COMP_W-1:0] sv [4];
	logic signed [COMP_W-1:0] ev [4];
	logic signed [COMP_W+WT_W:0] pe_s5 [4];
	logic signed [COMP_W+WT_W:0] ps_s5 [4];

	always_comb begin
		sw = side_q[P_DIV_END];
		if (sw.lin) begin
			ws_c = {(T_ONE - sw.item.blend_t), 14'b0};
			we_c = {sw.item.blend_t, 14'b0};
		end else begin
			ws_c = wa_div;
			we_c = wb_div;
		end
		wes_c = sw.flip ? -$signed({1'b0, we_c}) : $signed({1'b0, we_c});
		sv[0] = sw.item.start_w;
		sv[1] = sw.item.start_x;
		sv[2] = sw.item.start_y;
		sv[3] = sw.item.start_z;
		ev[0] = sw.item.end_w;
		ev[1] = sw.item.end_x;
		ev[2] = sw.item.end_y;
		ev[3] = sw.item.end_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				pe_s5[k] <= ev[k] * wes_c;
				ps_s5[k] <= sv[k] * $signed({1'b0, ws_c});
			end
		end
	end

	// Round half up, saturate and register the result.
	localparam logic signed [19:0] CMAX = 20'sd32767;
	localparam logic signed [19:0] CMIN = -20'sd32768;
	logic signed [COMP_W+WT_W+2:0] acc_c [4];
	logic signed [19:0] rnd_c [4];
	logic signed [COMP_W-1:0] res_c [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			acc_c[k] = (COMP_W+WT_W+3)'(pe_s5[k]) + (COMP_W+WT_W+3)'(ps_s5[k])
				+ (COMP_W+WT_W+3)'(1 << 29);
			rnd_c[k] = 20'(acc_c[k] >>> 30);
			if (rnd_c[k] > CMAX) begin
				res_c[k] = CMAX[COMP_W-1:0];
			end else if (rnd_c[k] < CMIN) begin
				res_c[k] = CMIN[COMP_W-1:0];
			end else begin
				res_c[k] = rnd_c[k][COMP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.out_w <= res_c[0];
			res_q.out_x <= res_c[1];
			res_q.out_y <= res_c[2];
			res_q.out_z <= res_c[3];
			res_q.used_linear <= side_q[P_WMUL].lin;
			res_q.flipped <= side_q[P_WMUL].flip;
		end
	end

endmodule
`default_nettype wire

/* rtl/qslerp_checker.sv */
`default_nettype none
`include "quaternion_slerp_top_defines.svh"
// Port-level checks for the slerp pipeline.
module qslerp_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input qslerp_pkg::slerp_out_t rsp_data
);
	import qslerp_pkg::*;

	// No result is shown while reset holds the pipeline empty.
	`QS_ASSERT_RESET(a_reset_empty, !rsp_valid, "result valid during reset")

	// The request side is only held back while a result waits.
	`QS_ASSERT_IMPL(a_stall_cause, req_stall, rsp_valid, "stall without a waiting result")

	// An empty output stage always lets a transaction in.
	`QS_ASSERT_IMPL(a_empty_accepts, !rsp_valid, !req_stall, "stalled with empty output")

	// A held result keeps its value.
	`QS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data),
		"held result changed")

endmodule

bind quaternion_slerp_top qslerp_checker u_qslerp_checker (.*);
`default_nettype wire

/* sim/quaternion_slerp_checker.sv */
`timescale 1ns / 1ps
module quaternion_slerp_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  qslerp_pkg::slerp_in_t req_data,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  qslerp_pkg::slerp_out_t rsp_data,
	input  logic cfg_we,
	input  logic [qslerp_pkg::THR_W-1:0] cfg_data,
	output int fail_count,
	output int pending_count
);
	import qslerp_pkg::*;

	localparam longint ONE = 64'sd1 << 30;

	// Arctangent table in Q30 radians.
	localparam longint ARC_TAB [16] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768
	};

	logic [THR_W-1:0] threshold;
	slerp_out_t blend_queue [$];

	// Integer square root of a nonnegative 64-bit value.
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Vectoring rotation: angle of the vector (x, y).
	function automatic longint vector_angle(longint x, longint y);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ARC_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ARC_TAB[i];
			end
		end
		return z;
	endfunction

	// Rotation mode: scaled sine of an angle.
	function automatic longint rot_sine(longint z);
		longint x, y, dx, dy;
		x = ONE;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARC_TAB[i];
			end else begin
				x += dx; y -= dy; z += ARC_TAB[i];
			end
		end
		return y;
	endfunction

	function automatic longint clamp_weight(longint num, longint den);
		longint w;
		w = (num * ONE) / den;
		if (w < 0) w = 0;
		if (w > ONE) w = ONE;
		return w;
	endfunction

	// Full blend of one request transaction.
	function automatic slerp_out_t blend_pair(slerp_in_t q, logic [THR_W-1:0] thr);
		longint sv [4], ev [4];
		longint dotp, ws, we, d, th, sth, acc, r;
		longint unsigned tt, sq;
		bit flip, lin;
		slerp_out_t o;
		sv = '{q.start_w, q.start_x, q.start_y, q.start_z};
		ev = '{q.end_w, q.end_x, q.end_y, q.end_z};
		tt = q.blend_t > 17'h10000 ? 65536 : q.blend_t;
		dotp = 0;
		for (int k = 0; k < 4; k++) dotp += sv[k] * ev[k];
		flip = dotp < 0;
		if (flip) dotp = -dotp;
		lin = 0;
		ws = 0;
		we = 0;
		if (ONE - dotp < longint'(thr)) begin
			lin = 1;
		end else begin
			d = dotp > ONE ? ONE : dotp;
			sq = int_sqrt((64'd1 << 60) - longint'(d * d));
			th = vector_angle(d, longint'(sq));
			if (th < 0) th = 0;
			sth = rot_sine(th);
			if (sth <= 0) begin
				lin = 1;
			end else begin
				ws = clamp_weight(rot_sine(longint'(((65536 - tt) * th) >> 16)), sth);
				we = clamp_weight(rot_sine(longint'((tt * th) >> 16)), sth);
			end
		end
		if (lin) begin
			ws = longint'((65536 - tt) << 14);
			we = longint'(tt << 14);
		end
		if (flip) we = -we;
		for (int k = 0; k < 4; k++) begin
			acc = ev[k] * we + sv[k] * ws + (64'sd1 << 29);
			r = acc >>> 30;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			case (k)
				0: o.out_w = r[15:0];
				1: o.out_x = r[15:0];
				2: o.out_y = r[15:0];
				default: o.out_z = r[15:0];
			endcase
		end
		o.used_linear = lin;
		o.flipped = flip;
		return o;
	endfunction

	assign pending_count = blend_queue.size();

	// Track the register, predict on requests and compare results.
	always @(posedge clk or negedge arst_n) begin
		slerp_out_t exp_o;
		if (!arst_n) begin
			threshold <= THR_RESET;
			fail_count <= 0;
			blend_queue.delete();
		end else begin
			if (cfg_we) threshold <= cfg_data;
			if (req_valid && !req_stall) blend_queue.push_back(blend_pair(req_data, threshold));
			if (rsp_valid && !rsp_stall) begin
				if (blend_queue.size() == 0) begin
					$display("%0t: expected no result actual %h", $realtime, rsp_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_o = blend_queue.pop_front();
					if (exp_o !== rsp_data) begin
						$display("%0t: expected %h actual %h", $realtime, exp_o, rsp_data);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* sim/quaternion_slerp_top_tb.sv */
`timescale 1ns / 1ps
module quaternion_slerp_top_tb;
	import qslerp_pkg::*;

	localparam int LATENCY = 101;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	slerp_in_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	slerp_out_t rsp_data;
	logic cfg_we;
	logic [THR_W-1:0] cfg_data;
	int fail_count;
	int pending_count;
	bit sink_calm;

	quaternion_slerp_top DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	quaternion_slerp_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly zero or short, now and then long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Result side stalls at random, with calm stretches.
	initial begin
		int n;
		rsp_stall = 0;
		@(posedge arst_n);
		forever begin
			n = sink_calm ? 0 : gap_len();
			if (n > 0) begin
				rsp_stall <= 1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	end

	// Send one request transaction, after an optional gap.
	task automatic send_pair(slerp_in_t q, bit gaps);
		int n;
		n = gaps ? gap_len() : 0;
		if (n > 0) begin
			req_valid <= 0;
			repeat (n) @(posedge clk);
		end
		req_valid <= 1;
		req_data <= q;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// Wait for all results, then let the pipeline drain before a write.
	task automatic drain_then_write(logic [THR_W-1:0] v);
		req_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic signed [15:0] rnd_comp();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Random pair: unit-like, near-parallel, opposite or raw noise.
	function automatic slerp_in_t rnd_pair();
		slerp_in_t q;
		int kind;
		kind = $urandom_range(9);
		q.start_w = rnd_comp(); q.start_x = rnd_comp();
		q.start_y = rnd_comp(); q.start_z = rnd_comp();
		q.end_w = rnd_comp(); q.end_x = rnd_comp();
		q.end_y = rnd_comp(); q.end_z = rnd_comp();
		if (kind < 4) begin
			q.start_w = 16'($urandom_range(32767, 20000));
			q.start_x = 16'($urandom_range(8000) - 4000);
			q.start_y = 16'($urandom_range(8000) - 4000);
			q.start_z = 16'($urandom_range(8000) - 4000);
			q.end_w = q.start_w - 16'($urandom_range(40));
			q.end_x = q.start_x + 16'($urandom_range(16)) - 16'd8;
			q.end_y = q.start_y + 16'($urandom_range(16)) - 16'd8;
			q.end_z = q.start_z + 16'($urandom_range(16)) - 16'd8;
			if (kind == 0) begin
				q.end_w = -q.end_w; q.end_x = -q.end_x;
				q.end_y = -q.end_y; q.end_z = -q.end_z;
			end
		end
		case ($urandom_range(4))
			0: q.blend_t = 17'h10000;
			1: q.blend_t = '0;
			2: q.blend_t = 17'($urandom);
			default: q.blend_t = 17'($urandom_range(65536));
		endcase
		return q;
	endfunction

	// Stimulus: directed corners, then random phases over several thresholds.
	initial begin
		slerp_in_t q;
		logic [THR_W-1:0] thr_set [4];
		int timer;
		thr_set = '{31'd0, 31'h4000_0000, 31'h7fff_ffff, 31'($urandom_range(1 << 24))};
		arst_n = 0;
		req_valid = 0;
		req_data = '0;
		cfg_we = 0;
		cfg_data = '0;
		sink_calm = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: identity, opposite, orthogonal and full-scale negative pairs at extremes of t.
		for (int i = 0; i < 12; i++) begin
			q = '0;
			q.start_w = 16'sh7fff;
			case (i % 4)
				0: q.end_w = 16'sh7fff;
				1: q.end_w = 16'sh8000;
				2: q.end_x = 16'sh7fff;
				default: begin
					q.start_w = 16'sh8000; q.start_x = 16'sh8000;
					q.start_y = 16'sh8000; q.start_z = 16'sh8000;
					q.end_w = 16'sh8000; q.end_x = 16'sh8000;
					q.end_y = 16'sh8000; q.end_z = 16'sh8000;
				end
			endcase
			q.blend_t = (i < 4) ? 17'd0 : (i < 8) ? 17'h10000 : 17'h1ffff;
			send_pair(q, 0);
		end
		q = '{16'sh5a82, 16'sh5a82, 16'sd0, 16'sd0, 16'sh5a82, 16'sd0, 16'sh5a82, 16'sd0,
			17'h8000};
		send_pair(q, 0);

		// Random phases, each under another threshold, the last with no sink stalls.
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) drain_then_write(thr_set[ph - 1]);
			sink_calm = (ph == 4);
			for (int i = 0; i < 128; i++) send_pair(rnd_pair(), ph != 4);
		end

		req_valid <= 0;
		timer = 0;
		while (pending_count != 0 && timer < 200000) begin
			@(posedge clk);
			timer++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule
